[sv/phase_slope_frequency_filter_macros.svh]
// Assertion macros used by the checker of the frequency filter.
`ifndef PHASE_SLOPE_FREQUENCY_FILTER_MACROS_SVH
`define PHASE_SLOPE_FREQUENCY_FILTER_MACROS_SVH

// Checked on every rising edge outside reset.
`define PSFF_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define PSFF_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/psff_pkg.sv]
`default_nettype none
package psff_pkg;

    localparam int MAX_TAPS = 32;
    localparam int TAP_W    = 6;
    localparam int IDX_W    = 5;
    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 32;
    localparam int W_W      = 8;
    localparam int A_W      = 43;
    localparam int B_W      = 17;
    localparam int ACC_W    = A_W + B_W;
    localparam int MAG_W    = 42;
    localparam int FRAC_W   = 16;

    localparam logic CFG_TAP_COUNT = 1'b0;
    localparam logic CFG_GAIN      = 1'b1;

    localparam logic [TAP_W-1:0]  TAP_RESET  = 6'd2;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

    localparam logic [DATA_W-1:0] FREQ_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] FREQ_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             shift;
        logic [IDX_W-1:0] rd_idx;
    } win_ctl_t;

endpackage
`default_nettype wire

[sv/phase_slope_frequency_filter.sv]
`default_nettype none
// A sample that fills the window gives its first result after the window
// multiply-accumulate on the shared MAC, then abs, two gain multiplies, saturate and
// the output load; further copies follow one a cycle while the output is not stalled.
// The input is not ready again until every result of the current sample has been loaded.
// Reset clears control, counts and output valid; tap_count and gain return to 2 and 1.0.
module phase_slope_frequency_filter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] phase
    input  wire logic [psff_pkg::DATA_W-1:0]   s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [31:0] frequency
    output logic      [psff_pkg::DATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast,
    // [0] short_record
    output logic                               m_axis_tuser,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [psff_pkg::GAIN_W-1:0]   cfg_wdata
);
    import psff_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_MLO  = 3'd3;
    localparam logic [2:0] ST_MHI  = 3'd4;
    localparam logic [2:0] ST_SAT  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [TAP_W-1:0]  tap_count_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [2:0]        state_reg, state_next;
    logic [TAP_W-1:0]  seen_reg, seen_next;
    logic [TAP_W-1:0]  n_reg, n_next;
    logic              last_reg, last_next;
    logic [TAP_W-1:0]  j_reg, j_next;
    logic [TAP_W-1:0]  cnt_reg, cnt_next;
    logic              short_reg, short_next;
    logic              neg_reg, neg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [DATA_W-1:0] freq_reg, freq_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_user_reg;

    logic              accept;
    logic              load_out;
    logic [TAP_W-1:0]  n_eff;
    logic [TAP_W-1:0]  old_seen;
    logic [TAP_W-1:0]  seen_new;
    logic [TAP_W-1:0]  lead;
    logic [TAP_W-1:0]  trail;
    logic [W_W-1:0]    weight;
    logic signed [ACC_W-1:0] acc_abs;
    logic              sat;
    logic [DATA_W-1:0] rd_data;
    win_ctl_t          win_ctl;

    logic signed [A_W-1:0]   mac_a;
    logic signed [B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0] mac_addend;
    logic signed [ACC_W-1:0] mac_sum;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        priority if (tap_count_reg < TAP_W'(2))
            n_eff = TAP_W'(2);
        else if (tap_count_reg > TAP_W'(MAX_TAPS))
            n_eff = TAP_W'(MAX_TAPS);
        else
            n_eff = tap_count_reg;
    end

    assign old_seen = (seen_reg > n_eff) ? n_eff : seen_reg;
    assign seen_new = (old_seen == n_eff) ? n_eff : old_seen + TAP_W'(1);
    assign lead     = n_eff - TAP_W'(2) - ((n_eff - TAP_W'(1)) >> 1);
    assign trail    = n_eff - TAP_W'(1) - lead;

    // Weight of the tap read in the cycle before: n + 1 - 2j.
    assign weight  = {2'b00, n_reg} + W_W'(1) - {1'b0, j_reg, 1'b0};
    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign sat     = |acc_reg[ACC_W-1:DATA_W-1];

    assign win_ctl.shift  = accept;
    assign win_ctl.rd_idx = j_reg[IDX_W-1:0];

    psff_window u_window (
        .clk     (clk),
        .ctl     (win_ctl),
        .wr_data (s_axis_tdata),
        .rd_data (rd_data)
    );

    always_comb
    begin
        mac_a      = '0;
        mac_b      = '0;
        mac_addend = '0;
        unique case (state_reg)
            ST_MAC:
            begin
                mac_a      = $signed({{(A_W-DATA_W){rd_data[DATA_W-1]}}, rd_data});
                mac_b      = (j_reg == '0) ? '0
                           : $signed({{(B_W-W_W){weight[W_W-1]}}, weight});
                mac_addend = acc_reg;
            end
            ST_MLO:
            begin
                mac_a = $signed({1'b0, mag_reg});
                mac_b = $signed({1'b0, gain_reg[FRAC_W-1:0]});
            end
            ST_MHI:
            begin
                mac_a      = $signed({1'b0, mag_reg});
                mac_b      = $signed({1'b0, gain_reg[GAIN_W-1:FRAC_W]});
                mac_addend = acc_reg >>> FRAC_W;
            end
            default:
            begin
                mac_a = '0;
            end
        endcase
    end

    psff_mac u_mac (
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_addend),
        .sum    (mac_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        short_next     = short_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        freq_next      = freq_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next    = n_eff;
                    last_next = s_axis_tlast;
                    seen_next = s_axis_tlast ? '0 : seen_new;
                    if (seen_new == n_eff)
                    begin
                        state_next = ST_MAC;
                        j_next     = '0;
                        acc_next   = '0;
                        short_next = 1'b0;
                        cnt_next   = ((old_seen != n_eff) ? lead + TAP_W'(1) : TAP_W'(1))
                                   + (s_axis_tlast ? trail : '0);
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_EMIT;
                        freq_next  = '0;
                        short_next = 1'b1;
                        cnt_next   = TAP_W'(1);
                    end
                end
            end
            ST_MAC:
            begin
                acc_next = mac_sum;
                j_next   = j_reg + TAP_W'(1);
                if (j_reg == n_reg)
                    state_next = ST_ABS;
            end
            ST_ABS:
            begin
                neg_next   = acc_reg[ACC_W-1];
                mag_next   = acc_abs[MAG_W-1:0];
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                acc_next   = mac_sum;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                acc_next   = mac_sum;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (neg_reg)
                    freq_next = sat ? FREQ_MIN : DATA_W'(0) - acc_reg[DATA_W-1:0];
                else
                    freq_next = sat ? FREQ_MAX : acc_reg[DATA_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Load only into a free or draining output slot.
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg - TAP_W'(1);
                    if (cnt_reg == TAP_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_RESET;
            gain_reg      <= GAIN_RESET;
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            n_reg         <= TAP_RESET;
            last_reg      <= 1'b0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TAP_COUNT: tap_count_reg <= cfg_wdata[TAP_W-1:0];
                    CFG_GAIN:      gain_reg      <= cfg_wdata;
                    default:       gain_reg      <= gain_reg;
                endcase
            end
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        short_reg <= short_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        mag_reg   <= mag_next;
        freq_reg  <= freq_next;
        if (load_out)
        begin
            out_data_reg <= freq_reg;
            out_last_reg <= last_reg && (cnt_reg == TAP_W'(1));
            out_user_reg <= short_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
`default_nettype wire

[sv/psff_mac.sv]
`default_nettype none
module psff_mac (
    input  wire logic signed [psff_pkg::A_W-1:0]   a,
    input  wire logic signed [psff_pkg::B_W-1:0]   b,
    input  wire logic signed [psff_pkg::ACC_W-1:0] addend,
    output logic signed      [psff_pkg::ACC_W-1:0] sum
);
    import psff_pkg::*;

    logic signed [ACC_W-1:0] prod;

    assign prod = a * b;
    assign sum  = addend + prod;

endmodule
`default_nettype wire

[sv/psff_window.sv]
`default_nettype none
module psff_window (
    input  wire logic                          clk,
    input  wire psff_pkg::win_ctl_t            ctl,
    input  wire logic [psff_pkg::DATA_W-1:0]   wr_data,
    output logic      [psff_pkg::DATA_W-1:0]   rd_data
);
    import psff_pkg::*;

    logic [DATA_W-1:0] win_reg [MAX_TAPS];
    logic [DATA_W-1:0] rd_reg;

    // Entry 0 holds the newest sample.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            win_reg[0] <= wr_data;
            for (int i = 1; i < MAX_TAPS; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
        rd_reg <= win_reg[ctl.rd_idx];
    end

    assign rd_data = rd_reg;

endmodule
`default_nettype wire

[sv/psff_checker.sv]
`default_nettype none
`include "phase_slope_frequency_filter_macros.svh"
module psff_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [psff_pkg::DATA_W-1:0]   s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [psff_pkg::DATA_W-1:0]   m_axis_tdata,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          m_axis_tuser,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [psff_pkg::GAIN_W-1:0]   cfg_wdata
);
    import psff_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, cfg_we, cfg_index, cfg_wdata};

    `PSFF_CHECK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped")
    `PSFF_CHECK(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "output data changed while stalled")
    `PSFF_CHECK(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "ready after final sample transfer")
    `PSFF_CHECK(a_short_final, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0, "short record result malformed")
    `PSFF_CHECK_RST(a_reset_idle, !rst_n |=> !m_axis_tvalid, "output valid during reset")

endmodule

bind phase_slope_frequency_filter psff_checker u_checker (.*);
`default_nettype wire

[sim/psff_stream_checker.sv]
`timescale 1ns / 100ps
module psff_stream_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    // [31:0] phase
    input  wire logic [psff_pkg::DATA_W-1:0] s_axis_tdata,
    input  wire logic                        s_axis_tlast,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [31:0] frequency
    input  wire logic [psff_pkg::DATA_W-1:0] m_axis_tdata,
    input  wire logic                        m_axis_tlast,
    // [0] short_record
    input  wire logic                        m_axis_tuser,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [psff_pkg::GAIN_W-1:0] cfg_wdata,
    output int unsigned                      outstanding,
    output int unsigned                      mismatches
);
    import psff_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DATA_W-1:0] freq;
        logic              end_rec;
        logic              is_short;
    } freq_result_t;

    freq_result_t      freq_expected[$];
    logic [DATA_W-1:0] window[MAX_TAPS];
    int                filled = 0;
    logic [DATA_W-1:0] held_freq = '0;
    logic [TAP_W-1:0]  tap_reg = TAP_RESET;
    logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
    int unsigned       fail_count = 0;

    function automatic logic [DATA_W-1:0] slope_frequency(input int n);
        longint     acc;
        logic [63:0] mag;
        logic [63:0] prod;
        acc = 0;
        for (int i = 0; i < n; i++)
            acc += longint'(2 * (i + 1) - (n + 1)) * longint'($signed(window[n - 1 - i]));
        mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        // Split the Q16.16 gain so the product stays inside 64 bits
        prod = mag * gain_reg[31:16] + ((mag * gain_reg[15:0]) >> 16);
        if (acc < 0)
            return (prod >= 64'h8000_0000) ? FREQ_MIN : 32'(64'd0 - prod);
        return (prod > 64'h7FFF_FFFF) ? FREQ_MAX : prod[31:0];
    endfunction

    task automatic clear_record();
        for (int i = 0; i < MAX_TAPS; i++) window[i] = '0;
        filled = 0;
        held_freq = '0;
    endtask

    task automatic expect_result(input logic [DATA_W-1:0] f, input logic eor, input logic shr);
        freq_result_t r;
        r.freq = f;
        r.end_rec = eor;
        r.is_short = shr;
        freq_expected.push_back(r);
    endtask

    task automatic absorb_sample(input logic [DATA_W-1:0] ph, input logic lst);
        int n;
        int lead;
        int trail;
        int prior;
        int copies;
        n = (tap_reg < 2) ? 2 : ((tap_reg > MAX_TAPS) ? MAX_TAPS : int'(tap_reg));
        lead = n - 2 - (n - 1) / 2;
        trail = n - 1 - lead;
        // A shorter window applies at once; a window that was full stays full
        prior = (filled > n) ? n : filled;
        for (int i = MAX_TAPS - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = ph;
        filled = (prior + 1 > n) ? n : prior + 1;
        if (filled == n)
        begin
            held_freq = slope_frequency(n);
            // Repeat for the leading edge on the first full window, trailing edge on last
            copies = 1 + ((prior < n) ? lead : 0) + (lst ? trail : 0);
            for (int k = 0; k < copies; k++)
                expect_result(held_freq, lst && (k == copies - 1), 1'b0);
        end
        else if (lst)
        begin
            expect_result('0, 1'b1, 1'b1);
        end
        if (lst) clear_record();
    endtask

    task automatic compare_result(input logic [DATA_W-1:0] f, input logic eor, input logic shr);
        freq_result_t want;
        if (freq_expected.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected transfer: frequency %h end %b short %b", f, eor, shr);
        end
        else
        begin
            want = freq_expected.pop_front();
            if (want != {f, eor, shr})
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("mismatch: expected frequency %h end %b short %b, got %h %b %b",
                             want.freq, want.end_rec, want.is_short, f, eor, shr);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_expected.delete();
            clear_record();
            tap_reg = TAP_RESET;
            gain_reg = GAIN_RESET;
            outstanding <= 0;
            mismatches <= fail_count;
        end
        else
        begin
            // Results leave before the sample of the same edge can produce any
            if (m_axis_tvalid && m_axis_tready)
                compare_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                absorb_sample(s_axis_tdata, s_axis_tlast);
            if (cfg_we)
            begin
                if (cfg_index == CFG_GAIN)
                    gain_reg = cfg_wdata;
                else
                    tap_reg = cfg_wdata[TAP_W-1:0];
            end
            outstanding <= freq_expected.size();
            mismatches <= fail_count;
        end
    end

endmodule

[sim/tb_phase_slope_frequency_filter.sv]
`timescale 1ns / 100ps
module tb_phase_slope_frequency_filter;
    import psff_pkg::*;

    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 48;
    localparam int CHOKE_CYCLES  = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_TAP_COUNT;
    logic [GAIN_W-1:0] cfg_wdata = '0;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          choke_req = 1'b0;
    logic [DATA_W-1:0] ramp_phase = '0;
    logic [DATA_W-1:0] ramp_step = '0;

    phase_slope_frequency_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    psff_stream_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: picks a new random stall pattern for each random span
    initial
    begin : receiver
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(posedge clk);
                if (choke_req)
                begin
                    // Hold off long enough for the block to back up into its input
                    choke_req = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (CHOKE_CYCLES) @(posedge clk);
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic offer_phase(input logic [DATA_W-1:0] ph, input logic lst);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ph;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
    endtask

    // Drain every expected result, then give a sample that fills the window time to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [GAIN_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] draw_phase(input int style);
        case (style)
            0:
            begin
                ramp_phase = ramp_phase + ramp_step + $urandom_range(0, 255) - 128;
                return ramp_phase;
            end
            1: return $urandom();
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    initial
    begin : stimulus
        int          items_sent;
        int          taps_now;
        int          records;
        int          len;
        int          style;
        int          sel;
        bit          closed;
        bit          choke_done;
        logic [5:0]  tap_val;
        logic [31:0] gain_val;

        items_sent = 0;
        choke_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config, two taps: saturate both ways, then a one-sample record
        offer_phase(32'h7FFF_FFFF, 1'b0);
        offer_phase(32'h8000_0000, 1'b0);
        offer_phase(32'h7FFF_FFFF, 1'b1);
        offer_phase(32'h0000_0000, 1'b1);

        // Tap count below range, largest gain
        settle();
        write_reg(CFG_TAP_COUNT, 32'd0);
        write_reg(CFG_GAIN, 32'hFFFF_FFFF);
        offer_phase(32'hFFFF_FFFF, 1'b0);
        offer_phase(32'h0000_0000, 1'b0);
        offer_phase(32'h0000_0001, 1'b1);

        // Tap count above range, zero gain, record too short
        settle();
        write_reg(CFG_TAP_COUNT, 32'd63);
        write_reg(CFG_GAIN, 32'd0);
        offer_phase(32'h0001_0000, 1'b0);
        offer_phase(32'h0002_0000, 1'b0);
        offer_phase(32'h0003_0000, 1'b0);
        offer_phase(32'h0004_0000, 1'b1);

        // Shrink the window in the middle of a record
        settle();
        write_reg(CFG_TAP_COUNT, 32'd4);
        write_reg(CFG_GAIN, 32'h0001_0000);
        offer_phase(32'd100, 1'b0);
        offer_phase(32'd300, 1'b0);
        offer_phase(32'd700, 1'b0);
        offer_phase(32'd1500, 1'b0);
        offer_phase(32'd3100, 1'b0);
        settle();
        write_reg(CFG_TAP_COUNT, 32'd2);
        offer_phase(-32'sd5000, 1'b1);

        // Grow the window in the middle of a record
        settle();
        write_reg(CFG_TAP_COUNT, 32'd1);
        write_reg(CFG_GAIN, 32'h0000_8000);
        offer_phase(32'd10, 1'b0);
        settle();
        write_reg(CFG_TAP_COUNT, 32'd3);
        offer_phase(32'd20, 1'b0);
        offer_phase(32'd40, 1'b0);
        offer_phase(32'd80, 1'b1);

        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            sel = $urandom_range(0, 15);
            case (sel)
                0: tap_val = 6'($urandom_range(0, 1));
                1: tap_val = 6'($urandom_range(33, 63));
                2: tap_val = 6'd32;
                3: tap_val = 6'($urandom_range(9, 31));
                default: tap_val = 6'($urandom_range(2, 8));
            endcase
            sel = $urandom_range(0, 7);
            case (sel)
                0: gain_val = 32'd0;
                1: gain_val = 32'hFFFF_FFFF;
                2: gain_val = $urandom();
                default: gain_val = $urandom() >> $urandom_range(8, 31);
            endcase
            // Occasionally keep the gain so one register changes alone
            write_reg(CFG_TAP_COUNT, 32'(tap_val));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_GAIN, gain_val);
            taps_now = (tap_val < 2) ? 2 : ((tap_val > MAX_TAPS) ? MAX_TAPS : int'(tap_val));

            if (!choke_done)
            begin
                choke_req = 1'b1;
                choke_done = 1'b1;
            end

            records = $urandom_range(1, 4);
            for (int r = 0; r < records; r++)
            begin
                sel = $urandom_range(0, 9);
                style = (sel < 6) ? 0 : ((sel < 9) ? 1 : 2);
                ramp_phase = $urandom();
                ramp_step = $urandom_range(0, 1 << 20) - (1 << 19);
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, taps_now - 1);
                else
                    len = $urandom_range(taps_now, taps_now + 20);
                // Leave the final record open now and then so the next config lands mid-record
                closed = !((r == records - 1) && ($urandom_range(0, 5) == 0));
                for (int k = 0; k < len; k++)
                    offer_phase(draw_phase(style), closed && (k == len - 1));
                items_sent += len;
            end
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
